// ===== hdl/tta_pkg.sv =====
package tta_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOEQ   = 2'd1,
        ST_UNPRED = 2'd2,
        ST_NOTIMP = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] arm_word;
        status_t     status;
        logic        may_read_pc;
        logic        may_write_pc;
    } tta_result_t;

    localparam logic [3:0] PC_REG = 4'd15;

endpackage

// ===== hdl/tta_channels.sv =====
interface tta_thumb_if;
    logic        valid;
    logic        ready;
    logic [15:0] thumb_word;

    modport source (output valid, output thumb_word, input ready);
    modport sink (input valid, input thumb_word, output ready);
endinterface

interface tta_arm_if;
    logic        valid;
    logic        ready;
    logic [31:0] arm_word;
    logic [1:0]  status;
    logic        may_read_pc;
    logic        may_write_pc;

    modport source (output valid, output arm_word, output status, output may_read_pc,
                    output may_write_pc, input ready);
    modport sink (input valid, input arm_word, input status, input may_read_pc,
                  input may_write_pc, output ready);
endinterface

// ===== hdl/thumb_to_arm_translator.sv =====
// Channel   Role    Payload
// instr     sink    thumb_word[15:0]
// result    source  arm_word[31:0], status[1:0], may_read_pc, may_write_pc
//
// One instruction per cycle while results are taken. Each instruction passes
// the instruction register and then the result register before it transfers out.
// The opcode priority match sits between the instruction register and the
// result register and sets the cycle time.
// Reset empties both stages; no result is pending after reset.
// A stalled result holds in its register while the instruction stage still
// takes one more word.
module thumb_to_arm_translator
    import tta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tta_thumb_if.sink   instr,
    tta_arm_if.source   result
);

    logic [15:0] instr_reg, instr_next;
    logic        s1_valid_reg, s1_valid_next;
    tta_result_t res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    tta_result_t dec;
    logic        out_free, s1_adv, in_take;

    tta_decode u_decode (
        .thumb_word (instr_reg),
        .res        (dec)
    );

    assign out_free    = !out_valid_reg || result.ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign instr.ready = !s1_valid_reg || out_free;
    assign in_take     = instr.valid && instr.ready;

    always_comb
    begin
        instr_next     = in_take ? instr.thumb_word : instr_reg;
        s1_valid_next  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        res_next       = s1_adv ? dec : res_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        instr_reg <= instr_next;
        res_reg   <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.arm_word     = res_reg.arm_word;
    assign result.status       = res_reg.status;
    assign result.may_read_pc  = res_reg.may_read_pc;
    assign result.may_write_pc = res_reg.may_write_pc;

    // A failed translation carries no encoding and no PC flags.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && res_reg.status != ST_OK |->
            res_reg.arm_word == '0 && !res_reg.may_read_pc && !res_reg.may_write_pc)
        else $error("failed translation carries an encoding or PC flag");

    a_pc_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.may_write_pc |-> result.may_read_pc)
        else $error("PC write flagged without PC read");

    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg && res_reg == $past(dec))
        else $error("decoded word did not reach the result register");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && instr_reg == $past(instr_reg))
        else $error("waiting instruction was lost");

endmodule

// ===== hdl/tta_decode.sv =====
module tta_decode
    import tta_pkg::*;
(
    input  logic [15:0] thumb_word,
    output tta_result_t res
);

    // Thumb opcode fields, named by how many top bits they cover.
    localparam logic [4:0] T5_LSL_IMM  = 5'h00;
    localparam logic [4:0] T5_ASR_IMM  = 5'h02;
    localparam logic [4:0] T5_ADD_I8   = 5'h06;
    localparam logic [4:0] T5_ADD_RSP  = 5'h15;
    localparam logic [4:0] T5_SUB_I8   = 5'h07;
    localparam logic [4:0] T5_MOV_IMM  = 5'h04;
    localparam logic [4:0] T5_LSR_IMM  = 5'h01;
    localparam logic [4:0] T5_LDMIA    = 5'h19;
    localparam logic [4:0] T5_LDR_IMM  = 5'h0D;
    localparam logic [4:0] T5_LDR_SP   = 5'h13;
    localparam logic [4:0] T5_LDRB_IMM = 5'h0F;
    localparam logic [4:0] T5_LDRH_IMM = 5'h11;
    localparam logic [4:0] T5_CMP_IMM  = 5'h05;
    localparam logic [4:0] T5_STMIA    = 5'h18;
    localparam logic [4:0] T5_STR_IMM  = 5'h0C;
    localparam logic [4:0] T5_STR_SP   = 5'h12;
    localparam logic [4:0] T5_STRB_IMM = 5'h0E;
    localparam logic [4:0] T5_STRH_IMM = 5'h10;

    localparam logic [6:0] T7_ADD_I3   = 7'h0E;
    localparam logic [6:0] T7_ADD_REG  = 7'h0C;
    localparam logic [6:0] T7_SUB_I3   = 7'h0F;
    localparam logic [6:0] T7_SUB_REG  = 7'h0D;
    localparam logic [6:0] T7_LDR_REG  = 7'h2C;
    localparam logic [6:0] T7_LDRB_REG = 7'h2E;
    localparam logic [6:0] T7_LDRSB    = 7'h2B;
    localparam logic [6:0] T7_LDRSH    = 7'h2F;
    localparam logic [6:0] T7_LDRH_REG = 7'h2D;
    localparam logic [6:0] T7_STR_REG  = 7'h28;
    localparam logic [6:0] T7_STRB_REG = 7'h2A;
    localparam logic [6:0] T7_STRH_REG = 7'h29;
    localparam logic [6:0] T7_PUSH     = 7'h5A;

    localparam logic [7:0] T8_ADD_HI   = 8'h44;
    localparam logic [7:0] T8_MOV_HI   = 8'h46;
    localparam logic [7:0] T8_CMP_HI   = 8'h45;

    localparam logic [8:0] T9_ADD_SP   = 9'h160;
    localparam logic [8:0] T9_SUB_SP   = 9'h161;

    localparam logic [9:0] T10_AND     = 10'h100;
    localparam logic [9:0] T10_ADC     = 10'h105;
    localparam logic [9:0] T10_BIC     = 10'h10E;
    localparam logic [9:0] T10_TST     = 10'h108;
    localparam logic [9:0] T10_SBC     = 10'h106;
    localparam logic [9:0] T10_ORR     = 10'h10C;
    localparam logic [9:0] T10_EOR     = 10'h101;
    localparam logic [9:0] T10_MVN     = 10'h10F;
    localparam logic [9:0] T10_LSL_REG = 10'h102;
    localparam logic [9:0] T10_LSR_REG = 10'h103;
    localparam logic [9:0] T10_NEG     = 10'h109;
    localparam logic [9:0] T10_MUL     = 10'h10D;
    localparam logic [9:0] T10_REV     = 10'h2E8;
    localparam logic [9:0] T10_ROR_REG = 10'h107;
    localparam logic [9:0] T10_SXTB    = 10'h2C9;
    localparam logic [9:0] T10_SXTH    = 10'h2C8;
    localparam logic [9:0] T10_UXTH    = 10'h2CA;
    localparam logic [9:0] T10_UXTB    = 10'h2CB;
    localparam logic [9:0] T10_CMP_REG = 10'h10A;

    // ARM base encodings with the always condition.
    localparam logic [31:0] A_LSL_IMM = 32'hE1B00000;
    localparam logic [31:0] A_ASR_IMM = 32'hE1B00040;
    localparam logic [31:0] A_AND     = 32'hE0100000;
    localparam logic [31:0] A_ADC     = 32'hE0B00000;
    localparam logic [31:0] A_ADDS_I  = 32'hE2900000;
    localparam logic [31:0] A_ADDS_R  = 32'hE0900000;
    localparam logic [31:0] A_ADD_HI  = 32'hE0800000;
    localparam logic [31:0] A_ADD_RSP = 32'hE28D0F00;
    localparam logic [31:0] A_ADD_SP  = 32'hE28DDF00;
    localparam logic [31:0] A_BIC     = 32'hE1D00000;
    localparam logic [31:0] A_TST     = 32'hE1100000;
    localparam logic [31:0] A_SUBS_I  = 32'hE2500000;
    localparam logic [31:0] A_SUBS_R  = 32'hE0500000;
    localparam logic [31:0] A_SUB_SP  = 32'hE24DDF00;
    localparam logic [31:0] A_SBC     = 32'hE0D00000;
    localparam logic [31:0] A_ORR     = 32'hE1900000;
    localparam logic [31:0] A_EOR     = 32'hE0300000;
    localparam logic [31:0] A_MOV_IMM = 32'hE3B00000;
    localparam logic [31:0] A_MOV_HI  = 32'hE1A00000;
    localparam logic [31:0] A_MVN     = 32'hE1F00000;
    localparam logic [31:0] A_LSL_REG = 32'hE1B00010;
    localparam logic [31:0] A_LSR_IMM = 32'hE1B00020;
    localparam logic [31:0] A_LSR_REG = 32'hE1B00030;
    localparam logic [31:0] A_NEG     = 32'hE2700000;
    localparam logic [31:0] A_MUL     = 32'hE0100090;
    localparam logic [31:0] A_REV     = 32'hE6BF0F30;
    localparam logic [31:0] A_ROR_REG = 32'hE1B00070;
    localparam logic [31:0] A_SXTB    = 32'hE6AF0070;
    localparam logic [31:0] A_SXTH    = 32'hE6BF0070;
    localparam logic [31:0] A_UXTH    = 32'hE6FF0070;
    localparam logic [31:0] A_UXTB    = 32'hE6EF0070;
    localparam logic [31:0] A_LDMIA   = 32'hE8900000;
    localparam logic [31:0] A_LDR_IMM = 32'hE5900000;
    localparam logic [31:0] A_LDR_REG = 32'hE7900000;
    localparam logic [31:0] A_LDR_SP  = 32'hE59D0000;
    localparam logic [31:0] A_LDRB_I  = 32'hE5D00000;
    localparam logic [31:0] A_LDRB_R  = 32'hE7D00000;
    localparam logic [31:0] A_LDRSB   = 32'hE19000D0;
    localparam logic [31:0] A_LDRSH   = 32'hE19000F0;
    localparam logic [31:0] A_LDRH_I  = 32'hE1D000B0;
    localparam logic [31:0] A_LDRH_R  = 32'hE19000B0;
    localparam logic [31:0] A_CMP_IMM = 32'hE3500000;
    localparam logic [31:0] A_CMP_REG = 32'hE1500000;
    localparam logic [31:0] A_STMIA   = 32'hE8A00000;
    localparam logic [31:0] A_STR_IMM = 32'hE5800000;
    localparam logic [31:0] A_STR_REG = 32'hE7800000;
    localparam logic [31:0] A_STR_SP  = 32'hE58D0000;
    localparam logic [31:0] A_STRB_I  = 32'hE5C00000;
    localparam logic [31:0] A_STRB_R  = 32'hE7C00000;
    localparam logic [31:0] A_STRH_I  = 32'hE1C000B0;
    localparam logic [31:0] A_STRH_R  = 32'hE18000B0;
    localparam logic [31:0] A_PUSH    = 32'hE92D0000;

    localparam logic [2:0] LOW_R7 = 3'd7;

    logic [4:0]  u5;
    logic [6:0]  u7;
    logic [7:0]  u8;
    logic [8:0]  u9;
    logic [9:0]  u10;
    logic [31:0] rd, rm, rn, rh, i5, i5hi, i8, i7, dh, mh;
    logic        h1, h2, inlist;

    assign u5     = thumb_word[15:11];
    assign u7     = thumb_word[15:9];
    assign u8     = thumb_word[15:8];
    assign u9     = thumb_word[15:7];
    assign u10    = thumb_word[15:6];
    assign h1     = thumb_word[7];
    assign h2     = thumb_word[6];
    assign rd     = {29'd0, thumb_word[2:0]};
    assign rm     = {29'd0, thumb_word[5:3]};
    assign rn     = {29'd0, thumb_word[8:6]};
    assign rh     = {29'd0, thumb_word[10:8]};
    assign i5     = {27'd0, thumb_word[10:6]};
    assign i5hi   = {30'd0, thumb_word[10:9]};
    assign i8     = {24'd0, thumb_word[7:0]};
    assign i7     = {25'd0, thumb_word[6:0]};
    assign dh     = {28'd0, h1, thumb_word[2:0]};
    assign mh     = {28'd0, h2, thumb_word[5:3]};
    assign inlist = thumb_word[thumb_word[10:8]];

    always_comb
    begin
        res.arm_word     = '0;
        res.status       = ST_OK;
        res.may_read_pc  = 1'b0;
        res.may_write_pc = 1'b0;
        priority if (u5 == T5_LSL_IMM)   res.arm_word = A_LSL_IMM | rd << 12 | i5 << 7 | rm;
        else if (u5 == T5_ASR_IMM)       res.arm_word = A_ASR_IMM | rd << 12 | i5 << 7 | rm;
        else if (u10 == T10_AND)         res.arm_word = A_AND | rd << 16 | rd << 12 | rm;
        else if (u10 == T10_ADC)         res.arm_word = A_ADC | rd << 16 | rd << 12 | rm;
        else if (u7 == T7_ADD_I3)        res.arm_word = A_ADDS_I | rm << 16 | rd << 12 | rn;
        else if (u5 == T5_ADD_I8)        res.arm_word = A_ADDS_I | rh << 16 | rh << 12 | i8;
        else if (u7 == T7_ADD_REG)       res.arm_word = A_ADDS_R | rm << 16 | rd << 12 | rn;
        else if (u8 == T8_ADD_HI)
        begin
            res.arm_word     = A_ADD_HI | dh << 16 | dh << 12 | mh;
            res.may_read_pc  = 1'b1;
            res.may_write_pc = (dh[3:0] == PC_REG);
        end
        else if (u5 == T5_ADD_RSP)       res.arm_word = A_ADD_RSP | rh << 12 | i8;
        else if (u9 == T9_ADD_SP)        res.arm_word = A_ADD_SP | i7;
        else if (u10 == T10_BIC)         res.arm_word = A_BIC | rd << 16 | rd << 12 | rm;
        else if (u10 == T10_TST)         res.arm_word = A_TST | rd << 16 | rm;
        else if (u7 == T7_SUB_I3)        res.arm_word = A_SUBS_I | rm << 16 | rd << 12 | rn;
        else if (u5 == T5_SUB_I8)        res.arm_word = A_SUBS_I | rh << 16 | rh << 12 | i8;
        else if (u7 == T7_SUB_REG)       res.arm_word = A_SUBS_R | rm << 16 | rd << 12 | rn;
        else if (u9 == T9_SUB_SP)        res.arm_word = A_SUB_SP | i7;
        else if (u10 == T10_SBC)         res.arm_word = A_SBC | rd << 16 | rd << 12 | rm;
        else if (u10 == T10_ORR)         res.arm_word = A_ORR | rd << 16 | rd << 12 | rm;
        else if (u10 == T10_EOR)         res.arm_word = A_EOR | rd << 16 | rd << 12 | rm;
        else if (u5 == T5_MOV_IMM)       res.arm_word = A_MOV_IMM | rh << 12 | i8;
        else if (u8 == T8_MOV_HI)
        begin
            res.arm_word     = A_MOV_HI | dh << 12 | mh;
            res.may_read_pc  = 1'b1;
            res.may_write_pc = (dh[3:0] == PC_REG);
        end
        else if (u10 == T10_MVN)         res.arm_word = A_MVN | rd << 12 | rm;
        else if (u10 == T10_LSL_REG)     res.arm_word = A_LSL_REG | rd << 12 | rm << 8 | rd;
        else if (u5 == T5_LSR_IMM)       res.arm_word = A_LSR_IMM | rd << 12 | i5 << 7 | rm;
        else if (u10 == T10_LSR_REG)     res.arm_word = A_LSR_REG | rd << 12 | rm << 8 | rd;
        else if (u10 == T10_NEG)         res.arm_word = A_NEG | rm << 16 | rd << 12;
        else if (u10 == T10_MUL)         res.arm_word = A_MUL | rd << 16 | rd << 8 | rm;
        else if (u10 == T10_REV)         res.arm_word = A_REV | rd << 12 | rm;
        else if (u10 == T10_ROR_REG)     res.arm_word = A_ROR_REG | rd << 12 | rm << 8 | rd;
        else if (u10 == T10_SXTB)        res.arm_word = A_SXTB | rd << 12 | rm;
        else if (u10 == T10_SXTH)        res.arm_word = A_SXTH | rd << 12 | rm;
        else if (u10 == T10_UXTH)        res.arm_word = A_UXTH | rd << 12 | rm;
        else if (u10 == T10_UXTB)        res.arm_word = A_UXTB | rd << 12 | rm;
        // Writeback only when the base register is not loaded from the list.
        else if (u5 == T5_LDMIA)
            res.arm_word = A_LDMIA | {10'd0, ~inlist, 21'd0} | rh << 16 | i8;
        else if (u5 == T5_LDR_IMM)       res.arm_word = A_LDR_IMM | rm << 16 | rd << 12 | i5 << 2;
        else if (u7 == T7_LDR_REG)       res.arm_word = A_LDR_REG | rm << 16 | rd << 12 | rn;
        else if (u5 == T5_LDR_SP)        res.arm_word = A_LDR_SP | rh << 12 | i8 << 2;
        else if (u5 == T5_LDRB_IMM)      res.arm_word = A_LDRB_I | rm << 16 | rd << 12 | i5;
        else if (u7 == T7_LDRB_REG)      res.arm_word = A_LDRB_R | rm << 16 | rd << 12 | rn;
        else if (u7 == T7_LDRSB)         res.arm_word = A_LDRSB | rm << 16 | rd << 12 | rn;
        else if (u7 == T7_LDRSH)         res.arm_word = A_LDRSH | rm << 16 | rd << 12 | rn;
        else if (u5 == T5_LDRH_IMM)
            res.arm_word = A_LDRH_I | rm << 16 | rd << 12 | i5hi << 8 | rn << 1;
        else if (u7 == T7_LDRH_REG)      res.arm_word = A_LDRH_R | rm << 16 | rd << 12 | rn;
        else if (u5 == T5_CMP_IMM)       res.arm_word = A_CMP_IMM | rh << 16 | i8;
        else if (u10 == T10_CMP_REG)     res.arm_word = A_CMP_REG | rd << 16 | rm;
        else if (u8 == T8_CMP_HI)
        begin
            priority if (!h1 && !h2)                       res.status = ST_UNPRED;
            else if (h2 && thumb_word[5:3] == LOW_R7)      res.status = ST_UNPRED;
            else if (h1 && thumb_word[2:0] == LOW_R7)      res.status = ST_NOTIMP;
            else res.arm_word = A_CMP_REG | dh << 16 | mh;
        end
        else if (u5 == T5_STMIA)         res.arm_word = A_STMIA | rh << 16 | i8;
        else if (u5 == T5_STR_IMM)       res.arm_word = A_STR_IMM | rm << 16 | rd << 12 | i5 << 2;
        else if (u7 == T7_STR_REG)       res.arm_word = A_STR_REG | rm << 16 | rd << 12 | rn;
        else if (u5 == T5_STR_SP)        res.arm_word = A_STR_SP | rh << 12 | i8 << 2;
        else if (u5 == T5_STRB_IMM)      res.arm_word = A_STRB_I | rm << 16 | rd << 12 | i5;
        else if (u7 == T7_STRB_REG)      res.arm_word = A_STRB_R | rm << 16 | rd << 12 | rn;
        else if (u5 == T5_STRH_IMM)
            res.arm_word = A_STRH_I | rm << 16 | rd << 12 | i5hi << 8 | rn << 1;
        else if (u7 == T7_STRH_REG)      res.arm_word = A_STRH_R | rm << 16 | rd << 12 | rn;
        // Bit 8 of the Thumb word selects LR, bit 14 of the ARM register list.
        else if (u7 == T7_PUSH)
            res.arm_word = A_PUSH | {17'd0, thumb_word[8], 14'd0} | i8;
        else                             res.status = ST_NOEQ;
    end

endmodule
